### rtl/core/lavv_pkg.sv
// Shared types, constants and arctangent table for the look-angle unit.
`default_nettype none

package lavv_pkg;

  // CORDIC geometry: Q2.30 rotation on a 32-bit-per-turn angle
  localparam int CORDIC_STEPS    = 24;
  localparam int XY_W            = 34;
  localparam int Z_W             = 33;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  // Configuration register indexes
  localparam logic REG_EYE_HEIGHT  = 1'b0;
  localparam logic REG_PITCH_LIMIT = 1'b1;

  localparam logic [13:0] PITCH_LIMIT_RST = 14'd12518;

  // One CORDIC vector as it moves from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_vec_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [29:0] atan_turn(input int unsigned i);
    logic [29:0] a;
    case (i)
      0:       a = 30'd536870912;
      1:       a = 30'd316933406;
      2:       a = 30'd167458907;
      3:       a = 30'd85004756;
      4:       a = 30'd42667331;
      5:       a = 30'd21354465;
      6:       a = 30'd10679838;
      7:       a = 30'd5340245;
      8:       a = 30'd2670163;
      9:       a = 30'd1335087;
      10:      a = 30'd667544;
      11:      a = 30'd333772;
      12:      a = 30'd166886;
      13:      a = 30'd83443;
      14:      a = 30'd41722;
      15:      a = 30'd20861;
      16:      a = 30'd10430;
      17:      a = 30'd5215;
      18:      a = 30'd2608;
      19:      a = 30'd1304;
      20:      a = 30'd652;
      21:      a = 30'd326;
      22:      a = 30'd163;
      23:      a = 30'd81;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lavv_cordic_cell.sv
// One CORDIC rotation cell: fixed shift and arctangent, registered output.
`default_nettype none

module lavv_cordic_cell
  import lavv_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire logic        clk,
  input  wire cordic_vec_t vec_in,
  output cordic_vec_t      vec_out
);

  logic signed [XY_W-1:0] x_in, y_in, dx, dy;
  logic signed [Z_W-1:0]  z_in, da;
  cordic_vec_t            vec_nxt;
  cordic_vec_t            vec_r;

  // shifted cross terms, arithmetic shift by this cell's step
  always_comb begin
    x_in = vec_in.x;
    y_in = vec_in.y;
    z_in = vec_in.z;
    dx   = y_in >>> STEP;
    dy   = x_in >>> STEP;
    da   = signed'(Z_W'(atan_turn(STEP)));
    // rotate toward zero residual; zero counts as positive
    if (!z_in[Z_W-1]) begin
      vec_nxt.x = x_in - dx;
      vec_nxt.y = y_in + dy;
      vec_nxt.z = z_in - da;
    end else begin
      vec_nxt.x = x_in + dx;
      vec_nxt.y = y_in - dy;
      vec_nxt.z = z_in + da;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign vec_out = vec_r;

endmodule

`default_nettype wire

### rtl/core/lavv_cordic_chain.sv
// Quadrant fold feeding a row of CORDIC cells for one angle.
`default_nettype none

module lavv_cordic_chain
  import lavv_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic [ANGLE_BITS-1:0]  angle,
  output logic signed [XY_W-1:0]      cos_raw,
  output logic signed [XY_W-1:0]      sin_raw,
  output logic                        flip
);

  logic [31:0]  turn32;
  logic [31:0]  folded;
  cordic_vec_t  link [0:CORDIC_STEPS];

  // widen to 32 bits per turn, fold second and third quadrants by a half turn
  always_comb begin
    turn32   = {angle, {(32-ANGLE_BITS){1'b0}}};
    flip     = turn32[31] ^ turn32[30];
    folded   = {turn32[31] ^ flip, turn32[30:0]};
    link[0].x = XY_W'(CORDIC_GAIN_Q30);
    link[0].y = '0;
    link[0].z = signed'(Z_W'(signed'(folded)));
  end

  // row of cells, one rotation step each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    lavv_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk     (clk),
      .vec_in  (link[i]),
      .vec_out (link[i+1])
    );
  end

  assign cos_raw = link[CORDIC_STEPS].x;
  assign sin_raw = link[CORDIC_STEPS].y;

endmodule

`default_nettype wire

### rtl/core/look_angles_to_view_vector_unit.sv
// An accepted beat passes S_RUN, S_TRIG, S_MUL and S_OUT before its result is registered;
// S_OUT waits until the output register is free. A new item is taken only once the
//   previous one has left S_OUT, since the 24-cell CORDIC chain runs from the held yaw and pitch registers.
// An item is accepted while an earlier result still waits in the output register.
// Reset (synchronous, rst_n low): control idle, yaw and pitch zero,
//   eye_height zero, pitch_limit 12518.
`default_nettype none

module look_angles_to_view_vector_unit
  import lavv_pkg::*;
#(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input beats
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_yaw_step,
  input  wire logic signed [15:0] in_pitch_step,
  input  wire logic signed [30:0] in_body_x,
  input  wire logic signed [30:0] in_body_y,
  input  wire logic signed [30:0] in_body_z,
  // result beats
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_eye_x,
  output logic signed [31:0]      out_eye_y,
  output logic signed [31:0]      out_eye_z,
  output logic signed [31:0]      out_look_x,
  output logic signed [31:0]      out_look_y,
  output logic signed [31:0]      out_look_z,
  output logic signed [15:0]      out_heading_x,
  output logic signed [15:0]      out_heading_z,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int PW      = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 2;
  localparam int QUARTER = 2**(ANGLE_BITS-2);
  localparam int TW      = TRIG_FRAC_BITS + 2;
  localparam int MW      = 2*TW;
  localparam int SH_T    = 30 - TRIG_FRAC_BITS;
  localparam int RND_T   = (2**SH_T)/2;
  localparam int ONE     = 2**TRIG_FRAC_BITS;
  localparam int SH_P    = 2*TRIG_FRAC_BITS - 8;
  localparam int RND_P   = (2**SH_P)/2;
  localparam int SH_Y    = TRIG_FRAC_BITS - 8;
  localparam int RND_Y   = (2**SH_Y)/2;
  localparam int CW      = $clog2(CORDIC_STEPS);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_TRIG, S_MUL, S_OUT} state_t;

  state_t                       state_r;
  logic [CW-1:0]                cnt_r;
  logic [ANGLE_BITS-1:0]        yaw_r;
  logic signed [ANGLE_BITS-1:0] pitch_r;
  logic [15:0]                  eye_height_r;
  logic [13:0]                  pitch_limit_r;
  logic signed [30:0]           body_x_r, body_y_r, body_z_r;
  logic signed [TW-1:0]         sy_r, cy_r, sp_r, cp_r;
  logic signed [MW-1:0]         prod_x_r, prod_z_r;
  logic signed [TW:0]           fy_r;
  logic                         out_valid_r;
  logic signed [31:0]           eye_x_r, eye_y_r, eye_z_r;
  logic signed [31:0]           look_x_r, look_y_r, look_z_r;
  logic signed [15:0]           heading_x_r, heading_z_r;

  logic [ANGLE_BITS-1:0]        yaw_nxt;
  logic signed [ANGLE_BITS-1:0] pitch_nxt;
  logic signed [PW-1:0]         p_sum, lim_eff;
  logic                         in_fire, out_free;
  logic signed [XY_W-1:0]       yc_raw, ys_raw, pc_raw, ps_raw;
  logic                         yaw_flip, pitch_flip;
  logic signed [MW-1:0]         fx_c, fz_c;
  logic signed [TW:0]           fy_c;
  logic signed [31:0]           ex_c, ey_c, ez_c;

  // Q2.30 to trig format: optional negate, round half up, clamp to +/- 1.0
  function automatic logic signed [TW-1:0] to_trig(input logic signed [XY_W-1:0] v,
                                                   input logic neg);
    logic signed [XY_W:0] a;
    logic signed [XY_W:0] r;
    a = neg ? -(XY_W+1)'(v) : (XY_W+1)'(v);
    r = (a + (XY_W+1)'(RND_T)) >>> SH_T;
    if (r > (XY_W+1)'(ONE)) begin
      r = (XY_W+1)'(ONE);
    end else if (r < -(XY_W+1)'(ONE)) begin
      r = -(XY_W+1)'(ONE);
    end
    return TW'(r);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // angle update: yaw wraps, pitch clamps to min(limit, quarter turn)
  always_comb begin
    yaw_nxt = yaw_r + ANGLE_BITS'(in_yaw_step);
    p_sum   = PW'(pitch_r) - PW'(in_pitch_step);
    lim_eff = (PW'(pitch_limit_r) > PW'(QUARTER)) ? PW'(QUARTER) : PW'(pitch_limit_r);
    if (p_sum > lim_eff) begin
      pitch_nxt = ANGLE_BITS'(lim_eff);
    end else if (p_sum < -lim_eff) begin
      pitch_nxt = ANGLE_BITS'(-lim_eff);
    end else begin
      pitch_nxt = ANGLE_BITS'(p_sum);
    end
  end

  // sine and cosine chains for yaw and pitch
  lavv_cordic_chain #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_yaw_chain (
    .clk     (clk),
    .angle   (yaw_r),
    .cos_raw (yc_raw),
    .sin_raw (ys_raw),
    .flip    (yaw_flip)
  );

  lavv_cordic_chain #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_pitch_chain (
    .clk     (clk),
    .angle   (pitch_r),
    .cos_raw (pc_raw),
    .sin_raw (ps_raw),
    .flip    (pitch_flip)
  );

  // forward vector rounding and eye position
  always_comb begin
    fx_c = (prod_x_r + MW'(RND_P)) >>> SH_P;
    fz_c = (prod_z_r + MW'(RND_P)) >>> SH_P;
    fy_c = ((TW+1)'(sp_r) + (TW+1)'(RND_Y)) >>> SH_Y;
    ex_c = 32'(body_x_r);
    ey_c = 32'(body_y_r) + signed'({16'd0, eye_height_r});
    ez_c = 32'(body_z_r);
  end

  // sequencer, angle state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      yaw_r         <= '0;
      pitch_r       <= '0;
      eye_height_r  <= '0;
      pitch_limit_r <= PITCH_LIMIT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EYE_HEIGHT:  eye_height_r  <= cfg_data;
          REG_PITCH_LIMIT: pitch_limit_r <= cfg_data[13:0];
          default:         ;
        endcase
      end
      // drained beat clears valid unless a new result loads this cycle
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            yaw_r    <= yaw_nxt;
            pitch_r  <= pitch_nxt;
            body_x_r <= in_body_x;
            body_y_r <= in_body_y;
            body_z_r <= in_body_z;
            cnt_r    <= '0;
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          // cells settle one per cycle from the held angles
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(CORDIC_STEPS-1)) begin
            state_r <= S_TRIG;
          end
        end
        S_TRIG: begin
          sy_r    <= to_trig(ys_raw, yaw_flip);
          cy_r    <= to_trig(yc_raw, yaw_flip);
          sp_r    <= to_trig(ps_raw, pitch_flip);
          cp_r    <= to_trig(pc_raw, pitch_flip);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_x_r <= cp_r * sy_r;
          prod_z_r <= cp_r * cy_r;
          fy_r     <= fy_c;
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            eye_x_r     <= ex_c;
            eye_y_r     <= ey_c;
            eye_z_r     <= ez_c;
            look_x_r    <= ex_c + 32'(fx_c);
            look_y_r    <= ey_c + 32'(fy_r);
            look_z_r    <= ez_c + 32'(fz_c);
            heading_x_r <= 16'(sy_r);
            heading_z_r <= 16'(cy_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_eye_x     = eye_x_r;
  assign out_eye_y     = eye_y_r;
  assign out_eye_z     = eye_z_r;
  assign out_look_x    = look_x_r;
  assign out_look_y    = look_y_r;
  assign out_look_z    = look_z_r;
  assign out_heading_x = heading_x_r;
  assign out_heading_z = heading_z_r;

endmodule

`default_nettype wire

### rtl/core/lavv_checker.sv
// Port-level checks for the look-angle unit, bound to the top level.
`default_nettype none

module lavv_checker #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_eye_x,
  input wire logic signed [15:0] out_heading_x,
  input wire logic signed [15:0] out_heading_z
);

  localparam logic signed [15:0] HMAX = (TRIG_FRAC_BITS <= 14) ?
                                        16'(2**TRIG_FRAC_BITS) : 16'sh7fff;

  // one item in flight: ready drops right after an accepted input beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // no result can appear the cycle after an input beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // heading stays on the unit circle range
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (TRIG_FRAC_BITS > 14) ||
                  (out_heading_x <= HMAX && out_heading_x >= -HMAX &&
                   out_heading_z <= HMAX && out_heading_z >= -HMAX))
    else $error("heading out of range");

  // stalled result beat stays valid and its eye_x unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_eye_x))
    else $error("stalled result beat changed");

endmodule

bind look_angles_to_view_vector_unit lavv_checker #(
  .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
) u_lavv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_eye_x     (out_eye_x),
  .out_heading_x (out_heading_x),
  .out_heading_z (out_heading_z)
);

`default_nettype wire

### verif/look_angles_to_view_vector_unit_tb.sv
// Self-checking testbench for the look-angle unit: camera predictor, traffic tasks, checker.
`default_nettype none

module look_angles_to_view_vector_unit_tb;
  import lavv_pkg::*;

  localparam int ANGLE_W        = 16;
  localparam int TRIG_FRAC      = 14;
  localparam int ROT_STEPS      = 24;
  localparam longint ROT_GAIN   = 652032874;
  localparam longint QUARTER    = 64'sd1 << (ANGLE_W - 2);
  localparam longint TRIG_ONE   = 64'sd1 << TRIG_FRAC;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RESULT_LATENCY = 40;

  // atan(2^-i) in units of 2^32 per turn
  localparam longint ATAN_TURN32 [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [15:0] yaw_step;
    logic signed [15:0] pitch_step;
    logic signed [30:0] body_x;
    logic signed [30:0] body_y;
    logic signed [30:0] body_z;
  } look_cmd_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_z;
  } view_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_yaw_step;
  logic signed [15:0] in_pitch_step;
  logic signed [30:0] in_body_x;
  logic signed [30:0] in_body_y;
  logic signed [30:0] in_body_z;

  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_eye_x;
  logic signed [31:0] out_eye_y;
  logic signed [31:0] out_eye_z;
  logic signed [31:0] out_look_x;
  logic signed [31:0] out_look_y;
  logic signed [31:0] out_look_z;
  logic signed [15:0] out_heading_x;
  logic signed [15:0] out_heading_z;

  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [15:0]        cfg_data;

  // Camera state as the block should hold it
  logic [15:0] yaw_acc;
  longint      pitch_acc;
  logic [15:0] eye_height_m;
  logic [13:0] pitch_limit_m;

  view_beat_t expected_views [$];
  int         error_count;
  int         idle_cycles;
  int         in_idle_pct;
  int         out_stall_pct;

  look_angles_to_view_vector_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_yaw_step   (in_yaw_step),
    .in_pitch_step (in_pitch_step),
    .in_body_x     (in_body_x),
    .in_body_y     (in_body_y),
    .in_body_z     (in_body_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_eye_x     (out_eye_x),
    .out_eye_y     (out_eye_y),
    .out_eye_z     (out_eye_z),
    .out_look_x    (out_look_x),
    .out_look_y    (out_look_y),
    .out_look_z    (out_look_z),
    .out_heading_x (out_heading_x),
    .out_heading_z (out_heading_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round half up, floor shift
  function automatic longint round_q(input longint v, input int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint to_trig(input longint q30);
    longint r;
    r = round_q(q30, 30 - TRIG_FRAC);
    if (r > TRIG_ONE) r = TRIG_ONE;
    if (r < -TRIG_ONE) r = -TRIG_ONE;
    return r;
  endfunction

  // Quadrant fold, then rotation-mode CORDIC on Q2.30
  function automatic void cordic_sin_cos(input logic [15:0] ang, output longint sn,
                                         output longint cs);
    logic [31:0] u;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    bit          flip;
    u = {ang, 16'h0000};
    flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
    if (flip) u[31] = ~u[31];
    z = {{32{u[31]}}, u};
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN32[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN32[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = to_trig(x);
    sn = to_trig(y);
  endfunction

  // Angle update first, then eye, target and heading from the new angles
  function automatic view_beat_t predict_view(input look_cmd_t cmd);
    view_beat_t v;
    longint     lim;
    longint     p;
    longint     sy;
    longint     cy;
    longint     sp;
    longint     cp;
    longint     ex;
    longint     ey;
    longint     ez;
    yaw_acc = yaw_acc + cmd.yaw_step;
    lim = longint'(pitch_limit_m);
    if (lim > QUARTER) lim = QUARTER;
    p = pitch_acc - longint'(cmd.pitch_step);
    if (p < -lim) p = -lim;
    if (p > lim) p = lim;
    pitch_acc = p;
    cordic_sin_cos(yaw_acc, sy, cy);
    cordic_sin_cos(p[15:0], sp, cp);
    ex = longint'(cmd.body_x);
    ey = longint'(cmd.body_y) + longint'(eye_height_m);
    ez = longint'(cmd.body_z);
    v.eye_x     = ex[31:0];
    v.eye_y     = ey[31:0];
    v.eye_z     = ez[31:0];
    v.look_x    = 32'(ex + round_q(cp * sy, 2 * TRIG_FRAC - 8));
    v.look_y    = 32'(ey + round_q(sp, TRIG_FRAC - 8));
    v.look_z    = 32'(ez + round_q(cp * cy, 2 * TRIG_FRAC - 8));
    v.heading_x = sy[15:0];
    v.heading_z = cy[15:0];
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_look(input look_cmd_t cmd);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_yaw_step   <= cmd.yaw_step;
    in_pitch_step <= cmd.pitch_step;
    in_body_x     <= cmd.body_x;
    in_body_y     <= cmd.body_y;
    in_body_z     <= cmd.body_z;
    do @(posedge clk); while (!in_ready);
    expected_views.push_back(predict_view(cmd));
    @(negedge clk);
  endtask

  // Stop sending and wait until every pending view has come back
  task automatic drain_views();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_views.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_EYE_HEIGHT) eye_height_m = value;
    else pitch_limit_m = value[13:0];
    @(negedge clk);
  endtask

  // Both registers, written only with the block drained
  task automatic set_config(input logic [15:0] height, input logic [15:0] limit);
    drain_views();
    write_reg(REG_EYE_HEIGHT, height);
    write_reg(REG_PITCH_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [30:0] random_body();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return $urandom_range(1) ? 31'h3FFF_FFFF - 31'($urandom_range(255))
                                  : 31'h4000_0000 + 31'($urandom_range(255));
      default: return 31'($urandom_range(131072) - 65536);
    endcase
  endfunction

  function automatic look_cmd_t random_look();
    look_cmd_t c;
    case ($urandom_range(3))
      0: c.yaw_step = 16'($urandom);
      1, 2: c.yaw_step = 16'($urandom_range(1024) - 512);
      default: c.yaw_step = 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
    endcase
    case ($urandom_range(3))
      0: c.pitch_step = 16'($urandom);
      1: c.pitch_step = 16'($urandom_range(8192) - 4096);
      default: c.pitch_step = 16'($urandom_range(512) - 256);
    endcase
    c.body_x = random_body();
    c.body_y = random_body();
    c.body_z = random_body();
    return c;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result checker: each beat against the oldest prediction
  always @(posedge clk) begin : check_views
    view_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_views.size() == 0) begin
        $display("%0t: view beat with none expected, expected nothing, actual eye_x %0d",
                 $time, out_eye_x);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        check_field("eye_x", want.eye_x, out_eye_x);
        check_field("eye_y", want.eye_y, out_eye_y);
        check_field("eye_z", want.eye_z, out_eye_z);
        check_field("look_x", want.look_x, out_look_x);
        check_field("look_y", want.look_y, out_look_y);
        check_field("look_z", want.look_z, out_look_z);
        check_field("heading_x", want.heading_x, out_heading_x);
        check_field("heading_z", want.heading_z, out_heading_z);
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
      $display("look_angles_to_view_vector_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset values: clamp at the default limit in both directions
  task automatic test_reset_defaults();
    send_look('{16'sh0000, 16'sh0000, 31'h0, 31'h0, 31'h0});
    send_look('{16'sh7FFF, 16'sh8000, 31'h1, 31'h7FFF_FFFF, 31'h100});
    send_look('{16'sh8000, 16'sh7FFF, 31'h7FFF_FF00, 31'h0, 31'h7FFF_FFFF});
  endtask

  // Body and height extremes, pitch mostly pinned at the widest limit
  task automatic test_field_extremes();
    set_config(16'hFFFF, 16'h3FFF);
    send_look('{16'sh1234, 16'sh8000, 31'h3FFF_FFFF, 31'h3FFF_FFFF, 31'h3FFF_FFFF});
    send_look('{16'shEDCC, 16'sh0000, 31'h4000_0000, 31'h4000_0000, 31'h4000_0000});
    send_look('{16'sh4000, 16'sh7FFF, 31'h3FFF_FFFF, 31'h4000_0000, 31'h3FFF_FFFF});
    send_look('{16'shAAAA, 16'sh5555, 31'h2AAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA});
    send_look('{16'sh5555, 16'shAAAA, 31'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555});
  endtask

  // Yaw on and next to every quadrant boundary
  task automatic test_quadrant_edges();
    logic [15:0] targets [9] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF,
                                 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    set_config(16'd256, 16'(PITCH_LIMIT_RST));
    foreach (targets[k]) begin
      send_look('{targets[k] - yaw_acc, (k % 2) ? 16'sd3000 : -16'sd3000,
                  31'(k * 1000), 31'h0, -31'sd5000});
    end
  endtask

  // Zero limit, upper data bits ignored on the limit, and a limit of one
  task automatic test_pitch_limits();
    set_config(16'h0000, 16'h0000);
    send_look('{16'sh0010, -16'sd100, 31'h0, 31'h0, 31'h0});
    set_config(16'h0001, 16'hFFFF);
    send_look('{16'sh0020, 16'sh8000, 31'h0, 31'h0, 31'h0});
    set_config(16'h0080, 16'h0001);
    send_look('{16'sh0030, 16'sd5, 31'h0, 31'h0, 31'h0});
  endtask

  // Random beats over several register settings and idle mixes
  task automatic test_random_traffic();
    int          in_pcts [4]  = '{0, 55, 0, 15};
    int          out_pcts [4] = '{0, 0, 55, 15};
    logic [15:0] height;
    logic [15:0] limit;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin height = 16'h0000; limit = 16'(PITCH_LIMIT_RST); end
        1: begin height = 16'hFFFF; limit = 16'h3FFF; end
        2: begin height = 16'($urandom_range(65535)); limit = 16'h0000; end
        3: begin height = 16'h0001; limit = 16'($urandom_range(65535)); end
        4: begin height = 16'hFFFF; limit = 16'h0000; end
        5: begin height = 16'h0000; limit = 16'h3FFF; end
        default: begin
          height = 16'($urandom_range(65535));
          limit  = 16'($urandom_range(65535));
        end
      endcase
      set_config(height, limit);
      in_idle_pct   = in_pcts[ph % 4];
      out_stall_pct = out_pcts[ph % 4];
      for (int n = 0; n < 160; n++) begin
        // sender holds off once per phase until all results are back
        if (n == 80) drain_views();
        send_look(random_look());
      end
    end
    in_idle_pct   = 0;
    out_stall_pct = 0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_yaw_step   = '0;
    in_pitch_step = '0;
    in_body_x     = '0;
    in_body_y     = '0;
    in_body_z     = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_EYE_HEIGHT;
    cfg_data      = '0;
    yaw_acc       = '0;
    pitch_acc     = 0;
    eye_height_m  = '0;
    pitch_limit_m = PITCH_LIMIT_RST;
    error_count   = 0;
    idle_cycles   = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_quadrant_edges();
    test_pitch_limits();
    test_random_traffic();

    drain_views();
    repeat (RESULT_LATENCY) @(negedge clk);
    if (error_count == 0) begin
      $display("look_angles_to_view_vector_unit_tb: done, clean");
    end else begin
      $display("look_angles_to_view_vector_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
